// ----- hdl/ihq_pkg.sv -----
package ihq_pkg;

  localparam int COUNT_W = 11;
  localparam int DIM_W = 11;
  localparam int NUM_CORNERS = 4;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_PIXEL = 2'd1,
    FUNC_QUERY = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_RANGE      = 2'd1,
    ST_INCOMPLETE = 2'd2,
    ST_BAD_INDEX  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_MODE   = 2'd0,
    REG_COUNT  = 2'd1,
    REG_WIDTH  = 2'd2,
    REG_HEIGHT = 2'd3
  } reg_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PIXEL,
    S_QUERY,
    S_DONE
  } state_t;

  typedef struct packed {
    logic accept;
    logic pix_run;
    logic qry_run;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  qry_ok;
    logic  sweep_done;
    logic  qry_done;
    logic  out_free;
  } sts_t;

endpackage

// ----- hdl/ihq_ctrl.sv -----
module ihq_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  ihq_pkg::sts_t   sts,
  output ihq_pkg::cmd_t   cmd
);

  ihq_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ihq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ihq_pkg::S_IDLE: begin
        if (in_valid) begin
          case (sts.func)
            ihq_pkg::FUNC_PIXEL: state_next = ihq_pkg::S_PIXEL;
            ihq_pkg::FUNC_QUERY: begin
              state_next = sts.qry_ok ? ihq_pkg::S_QUERY : ihq_pkg::S_DONE;
            end
            default: state_next = ihq_pkg::S_DONE;
          endcase
        end
      end
      ihq_pkg::S_PIXEL: if (sts.sweep_done) state_next = ihq_pkg::S_DONE;
      ihq_pkg::S_QUERY: if (sts.qry_done) state_next = ihq_pkg::S_DONE;
      ihq_pkg::S_DONE: if (sts.out_free) state_next = ihq_pkg::S_IDLE;
      default: state_next = ihq_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    in_stall     = (state != ihq_pkg::S_IDLE);
    cmd.accept   = (state == ihq_pkg::S_IDLE) && in_valid;
    cmd.pix_run  = (state == ihq_pkg::S_PIXEL);
    cmd.qry_run  = (state == ihq_pkg::S_QUERY);
    cmd.out_load = (state == ihq_pkg::S_DONE) && sts.out_free;
  end

endmodule

// ----- hdl/ihq_dp.sv -----
module ihq_dp #(
  parameter int MAX_WIDTH = 32,
  parameter int MAX_HEIGHT = 32,
  parameter int NUM_BINS = 256,
  parameter int MAX_DOMINANT = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  ihq_pkg::cmd_t   cmd,
  output ihq_pkg::sts_t   sts,
  input  logic            wr_en,
  input  logic [1:0]      wr_index,
  input  logic [5:0]      wr_data,
  input  logic [1:0]      func,
  input  logic [7:0]      pixel_value,
  input  logic [7:0]      saturation,
  input  logic [3:0]      entry_index,
  input  logic [4:0]      roi_x,
  input  logic [4:0]      roi_y,
  input  logic [5:0]      roi_width,
  input  logic [5:0]      roi_height,
  input  logic [7:0]      query_bin,
  input  logic            out_stall,
  output logic            out_valid,
  output logic [10:0]     bin_count,
  output logic [1:0]      status
);

  localparam int XW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int BW = $clog2(NUM_BINS);
  localparam int DW = (MAX_DOMINANT > 1) ? $clog2(MAX_DOMINANT) : 1;
  localparam int AW = YW + XW + BW;
  localparam int CW = BW + 1;
  localparam int CLW = (MAX_WIDTH < 63) ? MAX_WIDTH : 63;
  localparam int CLH = (MAX_HEIGHT < 63) ? MAX_HEIGHT : 63;
  localparam int CNTW = ihq_pkg::COUNT_W;
  localparam int DMW = ihq_pkg::DIM_W;

  // configuration
  logic       hist_mode;
  logic [4:0] dominant_count;
  logic [5:0] image_width;
  logic [5:0] image_height;

  // raster position and image state
  logic [XW-1:0] raster_column;
  logic [YW-1:0] raster_row;
  logic          image_complete;
  logic [XW-1:0] cur_x;
  logic [YW-1:0] cur_y;

  logic [15:0] dom_entry [MAX_DOMINANT];

  logic [CNTW-1:0] store_mem [2**AW];
  logic [CNTW-1:0] row_mem [2**BW];
  logic [CNTW-1:0] st_rdata;
  logic [CNTW-1:0] row_rdata;

  logic [CW-1:0]   cnt;
  logic            rd_v;
  logic [BW-1:0]   rd_tag;
  logic [BW-1:0]   pix_bin;
  logic            pix_hit;
  logic [BW-1:0]   q_bin;
  logic [XW-1:0]   qxa, qxb;
  logic [YW-1:0]   qya, qyb;
  logic [ihq_pkg::NUM_CORNERS-1:0] q_en;
  logic [CNTW-1:0] acc;
  ihq_pkg::status_t res_status;
  ihq_pkg::status_t status_q;
  logic [CNTW-1:0]  count_q;

  logic [5:0] eff_w, eff_h;
  logic [4:0] eff_entries;
  logic [6:0] x1, y1;
  logic       bin_ok;
  ihq_pkg::status_t q_status;
  logic          hit_k, hit_z;
  logic [BW-1:0] idx_k, idx_z;
  logic [BW-1:0] pix_bin_n;
  logic          pix_hit_n;
  logic [XW-1:0] x_base;
  logic [YW-1:0] y_base;
  logic          pix_issue, qry_issue;
  logic [AW-1:0] st_raddr;
  logic [AW-1:0] st_waddr;
  logic [CNTW-1:0] up_v, row_v, inc_v;
  ihq_pkg::func_t f;

  assign f = ihq_pkg::func_t'(func);

  always_comb begin
    eff_w = (image_width == 6'd0) ? 6'd1 :
            ((image_width > 6'(CLW)) ? 6'(CLW) : image_width);
    eff_h = (image_height == 6'd0) ? 6'd1 :
            ((image_height > 6'(CLH)) ? 6'(CLH) : image_height);
    eff_entries = (dominant_count > 5'(MAX_DOMINANT)) ? 5'(MAX_DOMINANT) : dominant_count;
  end

  // query checks
  always_comb begin
    x1 = 7'(roi_x) + 7'(roi_width) - 7'd1;
    y1 = 7'(roi_y) + 7'(roi_height) - 7'd1;
    bin_ok = hist_mode ? (query_bin < 8'(eff_entries)) : (9'(query_bin) < 9'(NUM_BINS));
    if (!image_complete) begin
      q_status = ihq_pkg::ST_INCOMPLETE;
    end else if (roi_width == 6'd0 || roi_height == 6'd0 || !bin_ok) begin
      q_status = ihq_pkg::ST_RANGE;
    end else if (x1 >= 7'(eff_w) || y1 >= 7'(eff_h)) begin
      q_status = ihq_pkg::ST_RANGE;
    end else begin
      q_status = ihq_pkg::ST_OK;
    end
  end

  // dominant table match, last matching entry wins
  always_comb begin
    hit_k = 1'b0;
    hit_z = 1'b0;
    idx_k = '0;
    idx_z = '0;
    for (int i = 0; i < MAX_DOMINANT; i++) begin
      if (5'(i) < eff_entries) begin
        if (dom_entry[i] == {pixel_value, saturation}) begin
          hit_k = 1'b1;
          idx_k = BW'(i);
        end
        if (dom_entry[i] == 16'd0) begin
          hit_z = 1'b1;
          idx_z = BW'(i);
        end
      end
    end
    if (hist_mode) begin
      pix_bin_n = hit_k ? idx_k : idx_z;
      pix_hit_n = hit_k || hit_z;
    end else begin
      pix_bin_n = BW'(pixel_value);
      pix_hit_n = 9'(pixel_value) < 9'(NUM_BINS);
    end
    x_base = image_complete ? '0 : raster_column;
    y_base = image_complete ? '0 : raster_row;
  end

  always_comb begin
    sts.func       = f;
    sts.qry_ok     = (q_status == ihq_pkg::ST_OK);
    sts.sweep_done = (cnt == CW'(NUM_BINS)) && !rd_v;
    sts.qry_done   = (cnt == CW'(ihq_pkg::NUM_CORNERS)) && !rd_v;
    sts.out_free   = !out_valid || !out_stall;
  end

  assign pix_issue = cmd.pix_run && (cnt < CW'(NUM_BINS));
  assign qry_issue = cmd.qry_run && (cnt < CW'(ihq_pkg::NUM_CORNERS));

  always_comb begin
    if (cmd.qry_run) begin
      case (cnt[1:0])
        2'd0: st_raddr = {qya, qxa, q_bin};
        2'd1: st_raddr = {qyb, qxa, q_bin};
        2'd2: st_raddr = {qya, qxb, q_bin};
        default: st_raddr = {qyb, qxb, q_bin};
      endcase
    end else begin
      st_raddr = {cur_y - 1'b1, cur_x, cnt[BW-1:0]};
    end
    st_waddr = {cur_y, cur_x, rd_tag};
    up_v  = (cur_y != '0) ? st_rdata : '0;
    row_v = (cur_x != '0) ? row_rdata : '0;
    inc_v = (pix_hit && rd_tag == pix_bin) ? CNTW'(1) : '0;
  end

  always_ff @(posedge clk) begin
    st_rdata  <= store_mem[st_raddr];
    row_rdata <= row_mem[cnt[BW-1:0]];
    if (cmd.pix_run && rd_v) begin
      store_mem[st_waddr] <= up_v + row_v + inc_v;
      row_mem[rd_tag]     <= row_v + inc_v;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && f == ihq_pkg::FUNC_LOAD && 5'(entry_index) < 5'(MAX_DOMINANT)) begin
      dom_entry[entry_index[DW-1:0]] <= {pixel_value, saturation};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_mode      <= 1'b0;
      dominant_count <= 5'd0;
      image_width    <= 6'd32;
      image_height   <= 6'd32;
      raster_column  <= '0;
      raster_row     <= '0;
      image_complete <= 1'b0;
      cnt            <= '0;
      rd_v           <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      rd_v <= pix_issue || qry_issue;
      if (pix_issue || qry_issue) cnt <= cnt + 1'b1;
      if (wr_en) begin
        case (ihq_pkg::reg_t'(wr_index))
          ihq_pkg::REG_MODE:   hist_mode <= wr_data[0];
          ihq_pkg::REG_COUNT:  dominant_count <= wr_data[4:0];
          ihq_pkg::REG_WIDTH:  image_width <= wr_data;
          ihq_pkg::REG_HEIGHT: image_height <= wr_data;
          default: ;
        endcase
        raster_column  <= '0;
        raster_row     <= '0;
        image_complete <= 1'b0;
      end
      if (cmd.accept) begin
        cnt <= '0;
        if (f == ihq_pkg::FUNC_PIXEL) begin
          image_complete <= 1'b0;
          if (DMW'(x_base) + DMW'(1) >= DMW'(eff_w)) begin
            raster_column <= '0;
            if (DMW'(y_base) + DMW'(1) >= DMW'(eff_h)) begin
              raster_row     <= '0;
              image_complete <= 1'b1;
            end else begin
              raster_row <= y_base + 1'b1;
            end
          end else begin
            raster_column <= x_base + 1'b1;
            raster_row    <= y_base;
          end
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item payload
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      acc     <= '0;
      cur_x   <= x_base;
      cur_y   <= y_base;
      pix_bin <= pix_bin_n;
      pix_hit <= pix_hit_n;
      q_bin   <= BW'(query_bin);
      qxa     <= XW'(x1);
      qya     <= YW'(y1);
      qxb     <= XW'(roi_x - 1'b1);
      qyb     <= YW'(roi_y - 1'b1);
      q_en    <= {(roi_x != 5'd0) && (roi_y != 5'd0), roi_x != 5'd0, roi_y != 5'd0, 1'b1};
      case (f)
        ihq_pkg::FUNC_LOAD: begin
          res_status <= (5'(entry_index) < 5'(MAX_DOMINANT)) ? ihq_pkg::ST_OK
                                                            : ihq_pkg::ST_BAD_INDEX;
        end
        ihq_pkg::FUNC_QUERY: res_status <= q_status;
        default: res_status <= ihq_pkg::ST_OK;
      endcase
    end else if (cmd.qry_run && rd_v && q_en[rd_tag[1:0]]) begin
      // corners on the diagonal add, the two others subtract
      if (rd_tag[1:0] == 2'd1 || rd_tag[1:0] == 2'd2) begin
        acc <= acc - st_rdata;
      end else begin
        acc <= acc + st_rdata;
      end
    end
    rd_tag <= cnt[BW-1:0];
    if (cmd.out_load) begin
      count_q  <= acc;
      status_q <= res_status;
    end
  end

  assign bin_count = count_q;
  assign status    = status_q;

endmodule

// ----- hdl/integral_histogram_region_query_top.sv -----
// a pixel sweeps every bin with one read and one write of the count memory per bin;
// a region query makes four corner reads through the single memory read port; a table
// load, a no-op or a rejected query goes straight to the result; one item at a time,
// no new transfer is taken until the item is through, and the next item is taken
// while the result waits
// synchronous reset clears configuration, raster position and handshakes, not the memories
module integral_histogram_region_query_top #(
  parameter int MAX_WIDTH = 32,
  parameter int MAX_HEIGHT = 32,
  parameter int NUM_BINS = 256,
  parameter int MAX_DOMINANT = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [5:0]  wr_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  func,
  input  logic [7:0]  pixel_value,
  input  logic [7:0]  saturation,
  input  logic [3:0]  entry_index,
  input  logic [4:0]  roi_x,
  input  logic [4:0]  roi_y,
  input  logic [5:0]  roi_width,
  input  logic [5:0]  roi_height,
  input  logic [7:0]  query_bin,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [10:0] bin_count,
  output logic [1:0]  status
);

  ihq_pkg::cmd_t cmd;
  ihq_pkg::sts_t sts;

  ihq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  ihq_dp #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_HEIGHT   (MAX_HEIGHT),
    .NUM_BINS     (NUM_BINS),
    .MAX_DOMINANT (MAX_DOMINANT)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .sts         (sts),
    .wr_en       (wr_en),
    .wr_index    (wr_index),
    .wr_data     (wr_data),
    .func        (func),
    .pixel_value (pixel_value),
    .saturation  (saturation),
    .entry_index (entry_index),
    .roi_x       (roi_x),
    .roi_y       (roi_y),
    .roi_width   (roi_width),
    .roi_height  (roi_height),
    .query_bin   (query_bin),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .bin_count   (bin_count),
    .status      (status)
  );

`ifndef SYNTHESIS
  a_pixel_busy: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && func == ihq_pkg::FUNC_PIXEL) |=> in_stall)
    else $error("pixel transfer did not start a sweep");

  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a finished item");

  a_count_only_ok: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ihq_pkg::ST_OK) |-> (bin_count == 11'd0))
    else $error("nonzero count on failed item");
`endif

endmodule

// ----- verif/tb_integral_histogram_region_query_top.sv -----
`timescale 1ns / 100ps

module tb_integral_histogram_region_query_top;

  localparam int IMG_MAX = 32;
  localparam int BINS = 256;
  localparam int SLOTS = 16;

  typedef struct {
    logic [10:0]       count;
    ihq_pkg::status_t  st;
  } hist_result_t;

  logic        clk;
  logic        rst;
  logic        wr_en;
  logic [1:0]  wr_index;
  logic [5:0]  wr_data;
  logic        in_valid;
  logic        in_stall;
  logic [1:0]  func;
  logic [7:0]  pixel_value;
  logic [7:0]  saturation;
  logic [3:0]  entry_index;
  logic [4:0]  roi_x;
  logic [4:0]  roi_y;
  logic [5:0]  roi_width;
  logic [5:0]  roi_height;
  logic [7:0]  query_bin;
  logic        out_valid;
  logic        out_stall;
  logic [10:0] bin_count;
  logic [1:0]  status;

  integral_histogram_region_query_top dut (
    .clk(clk), .rst(rst), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
    .in_valid(in_valid), .in_stall(in_stall), .func(func), .pixel_value(pixel_value),
    .saturation(saturation), .entry_index(entry_index), .roi_x(roi_x), .roi_y(roi_y),
    .roi_width(roi_width), .roi_height(roi_height), .query_bin(query_bin),
    .out_valid(out_valid), .out_stall(out_stall), .bin_count(bin_count), .status(status)
  );

  // shadow of the block's configuration and raster state
  logic [0:0]  hist_mode;
  logic [4:0]  dom_count;
  logic [5:0]  img_w_reg;
  logic [5:0]  img_h_reg;
  logic [15:0] dom_table [SLOTS];
  int          rast_col;
  int          rast_row;
  bit          img_done;
  int          pix_bin [IMG_MAX][IMG_MAX];

  hist_result_t pending_results[$];
  int  error_count;
  int  items_sent;
  bit  sender_no_gaps;
  bit  rx_no_stalls;
  int  rx_hold_cycles;
  bit  rx_took;

  always begin
    clk = 1'b1; #6;
    clk = 1'b0; #6;
  end

  function automatic int eff_w();
    if (img_w_reg == 0) return 1;
    return (img_w_reg > IMG_MAX) ? IMG_MAX : int'(img_w_reg);
  endfunction

  function automatic int eff_h();
    if (img_h_reg == 0) return 1;
    return (img_h_reg > IMG_MAX) ? IMG_MAX : int'(img_h_reg);
  endfunction

  function automatic int eff_slots();
    return (dom_count > SLOTS) ? SLOTS : int'(dom_count);
  endfunction

  function automatic int find_slot(logic [15:0] key);
    int hit;
    hit = -1;
    for (int i = 0; i < eff_slots(); i++)
      if (dom_table[i] == key) hit = i;
    return hit;
  endfunction

  function automatic void restart_raster();
    rast_col = 0;
    rast_row = 0;
    img_done = 0;
  endfunction

  function automatic void record_pixel(logic [7:0] val, logic [7:0] sat);
    int b;
    if (img_done) restart_raster();
    if (rast_col >= eff_w()) begin
      rast_col = 0;
      rast_row++;
    end
    if (rast_row >= eff_h()) restart_raster();
    if (hist_mode == 0) begin
      b = int'(val);
    end else begin
      b = find_slot({val, sat});
      if (b < 0) b = find_slot(16'h0000);
    end
    pix_bin[rast_row][rast_col] = b;
    rast_col++;
    if (rast_col >= eff_w()) begin
      rast_col = 0;
      rast_row++;
      if (rast_row >= eff_h()) begin
        rast_row = 0;
        img_done = 1;
      end
    end
  endfunction

  function automatic hist_result_t region_count(int x0, int y0, int rw, int rh, int qbin);
    hist_result_t r;
    int lim;
    int n;
    r.count = '0;
    r.st = ihq_pkg::ST_OK;
    lim = (hist_mode == 0) ? BINS : eff_slots();
    if (!img_done) begin
      r.st = ihq_pkg::ST_INCOMPLETE;
    end else if (rw == 0 || rh == 0 || qbin >= lim ||
                 x0 + rw - 1 >= eff_w() || y0 + rh - 1 >= eff_h()) begin
      r.st = ihq_pkg::ST_RANGE;
    end else begin
      n = 0;
      for (int y = y0; y < y0 + rh; y++)
        for (int x = x0; x < x0 + rw; x++)
          if (pix_bin[y][x] == qbin) n++;
      r.count = n[10:0];
    end
    return r;
  endfunction

  // predicts the result of the transfer that was just taken
  function automatic hist_result_t predict_item();
    hist_result_t r;
    r.count = '0;
    r.st = ihq_pkg::ST_OK;
    case (ihq_pkg::func_t'(func))
      ihq_pkg::FUNC_LOAD:  dom_table[entry_index] = {pixel_value, saturation};
      ihq_pkg::FUNC_PIXEL: record_pixel(pixel_value, saturation);
      ihq_pkg::FUNC_QUERY: r = region_count(int'(roi_x), int'(roi_y), int'(roi_width),
                                            int'(roi_height), int'(query_bin));
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_item(ihq_pkg::func_t f, int val, int sat, int slot,
                           int rx, int ry, int rw, int rh, int qbin);
    int gap;
    hist_result_t exp_r;
    gap = sender_no_gaps ? 0 : $urandom_range(0, 6);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    func <= f;
    pixel_value <= 8'(val);
    saturation <= 8'(sat);
    entry_index <= 4'(slot);
    roi_x <= 5'(rx);
    roi_y <= 5'(ry);
    roi_width <= 6'(rw);
    roi_height <= 6'(rh);
    query_bin <= 8'(qbin);
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall !== 1'b0);
    exp_r = predict_item();
    pending_results = {pending_results, exp_r};
    items_sent++;
  endtask

  task automatic send_pixel(logic [7:0] val, logic [7:0] sat);
    send_item(ihq_pkg::FUNC_PIXEL, int'(val), int'(sat), $urandom, $urandom, $urandom,
              $urandom, $urandom, $urandom);
  endtask

  task automatic send_query(int x, int y, int w, int h, int b);
    send_item(ihq_pkg::FUNC_QUERY, $urandom, $urandom, $urandom, x, y, w, h, b);
  endtask

  task automatic send_load(int slot, logic [15:0] key);
    send_item(ihq_pkg::FUNC_LOAD, int'(key[15:8]), int'(key[7:0]), slot, $urandom,
              $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic write_reg(ihq_pkg::reg_t idx, int val);
    wait_idle();
    repeat (4) @(negedge clk);
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= 6'(val);
    case (idx)
      ihq_pkg::REG_MODE:   hist_mode = val[0];
      ihq_pkg::REG_COUNT:  dom_count = val[4:0];
      ihq_pkg::REG_WIDTH:  img_w_reg = val[5:0];
      ihq_pkg::REG_HEIGHT: img_h_reg = val[5:0];
      default: ;
    endcase
    restart_raster();
    @(negedge clk);
    wr_en <= 1'b0;
  endtask

  task automatic set_image(int w, int h);
    write_reg(ihq_pkg::REG_WIDTH, w);
    write_reg(ihq_pkg::REG_HEIGHT, h);
  endtask

  // a mostly valid rectangle with a bin that is likely to be populated
  task automatic random_query();
    int x, y;
    if ($urandom_range(0, 9) == 0) begin
      send_query($urandom, $urandom, $urandom, $urandom, $urandom);
    end else begin
      x = $urandom_range(0, eff_w() - 1);
      y = $urandom_range(0, eff_h() - 1);
      send_query(x, y, $urandom_range(1, eff_w() - x), $urandom_range(1, eff_h() - y),
                 (hist_mode == 0) ? $urandom_range(0, 3) : $urandom_range(0, SLOTS));
    end
  endtask

  task automatic random_pixel();
    logic [15:0] key;
    if (hist_mode == 0) begin
      if ($urandom_range(0, 3) == 0) send_pixel(8'($urandom), 8'($urandom));
      else send_pixel(8'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      key = ($urandom_range(0, 3) == 0) ? 16'($urandom) : dom_table[$urandom_range(0, 15)];
      send_pixel(key[15:8], key[7:0]);
    end
  endtask

  task automatic test_gray_basic();
    set_image(3, 2);
    send_query(0, 0, 1, 1, 0);
    send_item(ihq_pkg::FUNC_NOP, 255, 255, 15, 31, 31, 63, 63, 255);
    send_pixel(8'd0, 8'd0);
    send_pixel(8'd255, 8'd255);
    send_pixel(8'd0, 8'd17);
    send_pixel(8'd128, 8'd0);
    send_query(0, 0, 3, 1, 0);
    send_pixel(8'd255, 8'd0);
    send_pixel(8'd0, 8'd0);
    send_query(0, 0, 3, 2, 0);
    send_query(1, 0, 2, 2, 255);
    send_query(2, 1, 1, 1, 0);
    send_query(0, 0, 0, 1, 0);
    send_query(0, 0, 1, 0, 0);
    send_query(1, 0, 3, 1, 0);
    send_query(31, 31, 32, 32, 128);
  endtask

  task automatic test_dominant_table();
    for (int i = 0; i < SLOTS; i++)
      send_load(i, (i == 5) ? 16'h0000 : {8'(i * 16 + 3), 8'(255 - i)});
    send_load(15, 16'hffff);
    send_load(9, {8'(9 * 16 + 3), 8'(255 - 9)});
    write_reg(ihq_pkg::REG_MODE, 1);
    write_reg(ihq_pkg::REG_COUNT, 16);
    set_image(4, 1);
    send_pixel(8'hff, 8'hff);
    send_pixel(8'h5a, 8'ha5);
    send_pixel(8'(10 * 16 + 3), 8'(255 - 10));
    send_pixel(8'h00, 8'h00);
    send_query(0, 0, 4, 1, 9);
    send_query(0, 0, 4, 1, 5);
    send_query(0, 0, 4, 1, 10);
    send_query(0, 0, 4, 1, 15);
    send_query(0, 0, 4, 1, 16);
    write_reg(ihq_pkg::REG_COUNT, 31);
    repeat (4) send_pixel(8'hff, 8'hff);
    send_query(0, 0, 4, 1, 15);
    write_reg(ihq_pkg::REG_COUNT, 4);
    repeat (4) send_pixel(8'h12, 8'h34);
    send_query(0, 0, 4, 1, 3);
    send_query(0, 0, 4, 1, 5);
    write_reg(ihq_pkg::REG_COUNT, 0);
    repeat (4) send_pixel(8'h00, 8'h00);
    send_query(0, 0, 4, 1, 0);
  endtask

  task automatic test_image_extremes();
    write_reg(ihq_pkg::REG_MODE, 0);
    set_image(63, 1);
    repeat (IMG_MAX) random_pixel();
    repeat (4) random_query();
    send_query(0, 0, 32, 1, 1);
    set_image(0, 32);
    repeat (IMG_MAX) random_pixel();
    repeat (4) random_query();
    send_query(0, 0, 1, 32, 2);
    set_image(1, 63);
    repeat (IMG_MAX + 5) random_pixel();
    send_query(0, 0, 1, 32, 3);
    send_query(0, 0, 1, 32, 3);
  endtask

  task automatic test_backpressure();
    set_image(2, 2);
    repeat (4) random_pixel();
    wait_idle();
    sender_no_gaps = 1;
    rx_hold_cycles = 300;
    repeat (12) random_query();
    repeat (6) send_load($urandom_range(0, 15), 16'($urandom));
    sender_no_gaps = 0;
  endtask

  task automatic test_random_images();
    int w, h, npix;
    while (items_sent < 900) begin
      write_reg(ihq_pkg::REG_MODE, $urandom_range(0, 1));
      if (hist_mode == 1) write_reg(ihq_pkg::REG_COUNT, $urandom_range(0, 31));
      set_image($urandom_range(1, 8), $urandom_range(1, 6));
      rx_no_stalls = ($urandom_range(0, 4) == 0);
      sender_no_gaps = ($urandom_range(0, 4) == 0);
      npix = eff_w() * eff_h();
      if ($urandom_range(0, 4) == 0) npix += $urandom_range(1, npix);
      for (int i = 0; i < npix; i++) begin
        random_pixel();
        case ($urandom_range(0, 19))
          0: random_query();
          1: send_load($urandom_range(0, 15), 16'($urandom));
          2: send_item(ihq_pkg::FUNC_NOP, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom, $urandom);
          default: ;
        endcase
      end
      repeat ($urandom_range(4, 12)) random_query();
      if ($urandom_range(0, 5) == 0) wait_idle();
    end
    sender_no_gaps = 0;
    rx_no_stalls = 0;
  endtask

  // receiver: random stall per transfer, plus an optional long hold-off
  initial begin
    int stall_left;
    out_stall = 1'b1;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (rx_took) begin
        rx_took = 0;
        stall_left = rx_no_stalls ? 0 : $urandom_range(0, 6);
      end
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        out_stall <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    hist_result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0) begin
      rx_took <= 1'b1;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result count=%0d status=%0d", $time, bin_count, status);
        error_count++;
      end else begin
        exp_r = pending_results.pop_front();
        if (bin_count !== exp_r.count) begin
          $display("%0t: bin_count expected %0d actual %0d", $time, exp_r.count, bin_count);
          error_count++;
        end
        if (status !== exp_r.st) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.st, status);
          error_count++;
        end
      end
    end
  end

  initial begin
    #15_000_000;
    $display("tb_integral_histogram_region_query_top: errors");
    $finish;
  end

  initial begin
    rst = 1'b1;
    wr_en = 1'b0;
    wr_index = ihq_pkg::REG_MODE;
    wr_data = '0;
    in_valid = 1'b0;
    func = ihq_pkg::FUNC_NOP;
    pixel_value = '0;
    saturation = '0;
    entry_index = '0;
    roi_x = '0;
    roi_y = '0;
    roi_width = '0;
    roi_height = '0;
    query_bin = '0;
    rx_took = 0;
    rx_hold_cycles = 0;
    rx_no_stalls = 0;
    sender_no_gaps = 0;
    error_count = 0;
    items_sent = 0;
    hist_mode = 0;
    dom_count = 0;
    img_w_reg = 32;
    img_h_reg = 32;
    for (int i = 0; i < SLOTS; i++) dom_table[i] = '0;
    restart_raster();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_gray_basic();
    test_dominant_table();
    test_image_extremes();
    test_backpressure();
    test_random_images();

    wait_idle();
    repeat (300) @(negedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("tb_integral_histogram_region_query_top: clean");
    end else begin
      $display("tb_integral_histogram_region_query_top: errors");
    end
    $finish;
  end

endmodule
